// ===== src/eslm_pkg.sv =====
// Shared types and constants for the e-switch light mode controller.
// Used by eslm_core and eswitch_light_mode_controller; no dependencies.
package eslm_pkg;

    localparam int MAX_MODES         = 8;
    localparam int DEBOUNCE_SAMPLES  = 4;
    localparam int STEPDOWN_READINGS = 4;

    localparam logic [7:0] STROBE_LEVEL = 8'hFF;
    localparam logic [7:0] COUNT_MAX    = 8'hFF;
    localparam logic [2:0] LOWCNT_MAX   = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [2:0] REG_XLONG_PRESS  = 3'd1;
    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_BATT_LOW     = 3'd3;
    localparam logic [2:0] REG_BATT_CRIT    = 3'd4;
    localparam logic [2:0] REG_BATT_DELAY   = 3'd5;
    localparam logic [2:0] REG_MODE_COUNT   = 3'd6;
    localparam logic [2:0] REG_MODE_LEVELS  = 3'd7;

    // configuration reset values
    localparam logic [7:0]  RST_LONG_PRESS   = 8'd21;
    localparam logic [7:0]  RST_XLONG_PRESS  = 8'd48;
    localparam logic [7:0]  RST_IDLE_TIMEOUT = 8'd75;
    localparam logic [7:0]  RST_BATT_LOW     = 8'd130;
    localparam logic [7:0]  RST_BATT_CRIT    = 8'd115;
    localparam logic [7:0]  RST_BATT_DELAY   = 8'd188;
    localparam logic [3:0]  RST_MODE_COUNT   = 4'd5;
    localparam logic [63:0] RST_MODE_LEVELS  = 64'd1096928723200;

    // sleep phase codes
    localparam logic [1:0] PH_AWAKE  = 2'd0;
    localparam logic [1:0] PH_DRAIN  = 2'd1;
    localparam logic [1:0] PH_ASLEEP = 2'd2;

    typedef struct packed {
        logic [7:0]  long_press;
        logic [7:0]  xlong_press;
        logic [7:0]  idle_timeout;
        logic [7:0]  batt_low;
        logic [7:0]  batt_crit;
        logic [7:0]  batt_delay;
        logic [3:0]  mode_count;
        logic [63:0] mode_levels;
    } t_cfg;

    typedef struct packed {
        logic [2:0] mode;
        logic       strobe;
        logic [3:0] saved;    // bit 3 marks strobe
        logic [7:0] press;
        logic [7:0] idle;
        logic [7:0] bwait;
        logic [2:0] lowcnt;
        logic [1:0] phase;
    } t_state;

endpackage

// ===== src/eslm_core.sv =====
// Next-state and result logic for one tick of the mode controller.
// Purely combinational; depends on eslm_pkg.
module eslm_core #(
    parameter int DEBOUNCE_SAMPLES = eslm_pkg::DEBOUNCE_SAMPLES
) (
    input  eslm_pkg::t_state              i_state,
    input  logic [DEBOUNCE_SAMPLES-1:0]   i_hist,
    input  eslm_pkg::t_cfg                i_cfg,
    input  logic                          i_switch_low,
    input  logic                          i_adc_ready,
    input  logic [7:0]                    i_adc_value,
    output eslm_pkg::t_state              o_state,
    output logic [DEBOUNCE_SAMPLES-1:0]   o_hist,
    output logic [2:0]                    o_mode_index,
    output logic                          o_strobe_on,
    output logic [7:0]                    o_pwm_level
);
    import eslm_pkg::*;

    typedef struct packed {
        logic [3:0] saved;
        logic [2:0] mode;
        logic       strobe;
    } t_step;

    logic [DEBOUNCE_SAMPLES:0] hist_wide;
    logic                      held;
    logic [3:0]                n_used;
    logic [2:0]                top_mode;

    assign hist_wide = {i_hist, i_switch_low};
    assign o_hist    = hist_wide[DEBOUNCE_SAMPLES-1:0];
    assign held      = (o_hist != '0);

    always_comb begin
        priority if (i_cfg.mode_count < 4'd2) begin
            n_used = 4'd2;
        end else if (i_cfg.mode_count > 4'(MAX_MODES)) begin
            n_used = 4'(MAX_MODES);
        end else begin
            n_used = i_cfg.mode_count;
        end
    end
    assign top_mode = 3'(n_used - 4'd1);

    function automatic t_step step_prev(input logic [2:0] mode, input logic strobe,
                                        input logic [2:0] top, input logic [3:0] used);
        t_step r;
        r.saved  = {strobe, mode};
        r.strobe = 1'b0;
        if (strobe || mode == 3'd0 || {1'b0, mode} >= used) begin
            r.mode = top;
        end else begin
            r.mode = mode - 3'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] level_of(input logic [63:0] levels, input logic [2:0] m);
        return levels[{m, 3'b000} +: 8];
    endfunction

    always_comb begin
        t_state     s;
        t_step      st;
        logic [7:0] limit;
        logic [3:0] before_code;
        logic [3:0] after_code;
        s  = i_state;
        st = '0;
        limit = i_cfg.batt_low;

        if (s.phase == PH_ASLEEP && i_switch_low) begin
            s.phase = PH_AWAKE;
        end

        before_code = {s.strobe, s.mode};
        after_code  = before_code;

        unique case (s.phase)
            PH_DRAIN: begin
                if (held) begin
                    if (s.press != COUNT_MAX) begin
                        s.press = s.press + 8'd1;
                        if (s.press == i_cfg.xlong_press) begin
                            s.strobe = 1'b1;
                            s.phase  = PH_AWAKE;
                        end
                    end
                end else begin
                    s.press = 8'd0;
                    s.phase = PH_ASLEEP;
                end
            end
            PH_AWAKE: begin
                if (held) begin
                    if (s.press != COUNT_MAX) s.press = s.press + 8'd1;
                    if (s.press == i_cfg.long_press) begin
                        st       = step_prev(s.mode, s.strobe, top_mode, n_used);
                        s.saved  = st.saved;
                        s.mode   = st.mode;
                        s.strobe = st.strobe;
                        s.idle   = 8'd0;
                    end
                    if (s.press == i_cfg.xlong_press) s.strobe = 1'b1;
                    s.bwait = i_cfg.batt_delay;
                end else begin
                    if (s.press != 8'd0 && s.press < i_cfg.long_press) begin
                        if (s.strobe) begin
                            s.mode   = s.saved[2:0];
                            s.strobe = s.saved[3];
                        end else begin
                            s.saved = {1'b0, s.mode};
                            if ({1'b0, s.mode} + 4'd1 >= n_used) begin
                                s.mode = 3'd0;
                            end else begin
                                s.mode = s.mode + 3'd1;
                            end
                            if (s.idle >= i_cfg.idle_timeout) s.mode = 3'd0;
                            s.idle = 8'd0;
                        end
                    end else begin
                        if (s.idle != COUNT_MAX) s.idle = s.idle + 8'd1;
                        if (s.bwait != 8'd0) s.bwait = s.bwait - 8'd1;
                        if (s.bwait == 8'd0) begin
                            if (i_adc_ready) begin
                                // mode one runs down to the critical level
                                limit = (!s.strobe && s.mode == 3'd1) ? i_cfg.batt_crit
                                                                      : i_cfg.batt_low;
                                if (i_adc_value < limit) begin
                                    if (s.lowcnt != LOWCNT_MAX) s.lowcnt = s.lowcnt + 3'd1;
                                end else begin
                                    s.lowcnt = 3'd0;
                                end
                            end
                            if (s.lowcnt >= 3'(STEPDOWN_READINGS)) begin
                                st       = step_prev(s.mode, s.strobe, top_mode, n_used);
                                s.saved  = st.saved;
                                s.mode   = st.mode;
                                s.strobe = st.strobe;
                                s.lowcnt = 3'd0;
                                s.bwait  = i_cfg.batt_delay;
                            end
                        end
                    end
                    s.press = 8'd0;
                end
                after_code = {s.strobe, s.mode};
                if (after_code != before_code && !s.strobe
                    && level_of(i_cfg.mode_levels, s.mode) == 8'd0) begin
                    s.phase = PH_DRAIN;
                end
            end
            default: begin
                // asleep with switch released: nothing moves
            end
        endcase

        o_state = s;
    end

    assign o_mode_index = o_state.mode;
    assign o_strobe_on  = o_state.strobe;
    assign o_pwm_level  = o_state.strobe ? STROBE_LEVEL
                                         : level_of(i_cfg.mode_levels, o_state.mode);

endmodule

// ===== src/eswitch_light_mode_controller.sv =====
// Top level of the e-switch light mode controller: config registers, tick state,
// two-entry result stage. Depends on eslm_pkg and eslm_core.

// One tick item is taken every clock cycle while input ready is high and gives one
// registered result (mode index, strobe flag, PWM level); the state register updates
// once per item through a single combinational pass, which sets the rate at one item
// per cycle. A two-entry result stage keeps the input ready for one more item while a
// result waits; input ready drops only when both entries are full. Config writes are
// always ready and take effect on the next item.
module eswitch_light_mode_controller #(
    parameter int DEBOUNCE_SAMPLES = eslm_pkg::DEBOUNCE_SAMPLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_switch_low,
    input  logic        i_adc_ready,
    input  logic [7:0]  i_adc_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_mode_index,
    output logic        o_strobe_on,
    output logic [7:0]  o_pwm_level,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import eslm_pkg::*;

    t_cfg                        r_cfg;
    t_state                      r_state;
    logic [DEBOUNCE_SAMPLES-1:0] r_hist;
    t_state                      n_state;
    logic [DEBOUNCE_SAMPLES-1:0] n_hist;

    logic [2:0] n_mode;
    logic       n_strobe;
    logic [7:0] n_pwm;

    logic       r_out_valid;
    logic [2:0] r_out_mode;
    logic       r_out_strobe;
    logic [7:0] r_out_pwm;
    logic       r_skid_valid;
    logic [2:0] r_skid_mode;
    logic       r_skid_strobe;
    logic [7:0] r_skid_pwm;

    logic in_acc;
    logic out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    eslm_core #(
        .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
    ) u_core (
        .i_state      (r_state),
        .i_hist       (r_hist),
        .i_cfg        (r_cfg),
        .i_switch_low (i_switch_low),
        .i_adc_ready  (i_adc_ready),
        .i_adc_value  (i_adc_value),
        .o_state      (n_state),
        .o_hist       (n_hist),
        .o_mode_index (n_mode),
        .o_strobe_on  (n_strobe),
        .o_pwm_level  (n_pwm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{long_press:   RST_LONG_PRESS,
                       xlong_press:  RST_XLONG_PRESS,
                       idle_timeout: RST_IDLE_TIMEOUT,
                       batt_low:     RST_BATT_LOW,
                       batt_crit:    RST_BATT_CRIT,
                       batt_delay:   RST_BATT_DELAY,
                       mode_count:   RST_MODE_COUNT,
                       mode_levels:  RST_MODE_LEVELS};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LONG_PRESS:   r_cfg.long_press   <= i_cfg_data[7:0];
                REG_XLONG_PRESS:  r_cfg.xlong_press  <= i_cfg_data[7:0];
                REG_IDLE_TIMEOUT: r_cfg.idle_timeout <= i_cfg_data[7:0];
                REG_BATT_LOW:     r_cfg.batt_low     <= i_cfg_data[7:0];
                REG_BATT_CRIT:    r_cfg.batt_crit    <= i_cfg_data[7:0];
                REG_BATT_DELAY:   r_cfg.batt_delay   <= i_cfg_data[7:0];
                REG_MODE_COUNT:   r_cfg.mode_count   <= i_cfg_data[3:0];
                REG_MODE_LEVELS:  r_cfg.mode_levels  <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode:   3'd0,
                         strobe: 1'b0,
                         saved:  4'd0,
                         press:  8'd0,
                         idle:   8'd0,
                         bwait:  RST_BATT_DELAY,
                         lowcnt: 3'd0,
                         phase:  PH_DRAIN};
            r_hist  <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
            r_hist  <= n_hist;
        end
    end

    // result stage: output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_mode   <= r_skid_mode;
                r_out_strobe <= r_skid_strobe;
                r_out_pwm    <= r_skid_pwm;
            end else if (in_acc) begin
                r_out_mode   <= n_mode;
                r_out_strobe <= n_strobe;
                r_out_pwm    <= n_pwm;
            end
        end else if (in_acc) begin
            r_skid_mode   <= n_mode;
            r_skid_strobe <= n_strobe;
            r_skid_pwm    <= n_pwm;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode_index = r_out_mode;
    assign o_strobe_on  = r_out_strobe;
    assign o_pwm_level  = r_out_pwm;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with output register empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_out_valid && !i_out_ready) |=> !o_in_ready)
        else $error("item taken during stall but skid not filled");

    a_strobe_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_strobe_on) |-> (o_pwm_level == STROBE_LEVEL))
        else $error("strobe result without full drive level");
`endif

endmodule

// ===== tb/eswitch_light_mode_controller_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for eswitch_light_mode_controller: directed and random
// switch/battery ticks, a tracking model of the mode logic and an in-order result check.
// Depends on eslm_pkg and the RTL of the controller.
module eswitch_light_mode_controller_test;
    import eslm_pkg::*;

    typedef struct {
        logic [2:0]  mode;
        logic        strobe;
        logic [7:0]  pwm;
        int unsigned tick;
    } t_lamp;

    // Tracks the light's mode logic per accepted tick and checks the lamp outputs.
    class mode_tracker;
        t_cfg   cfg;
        t_state st;
        logic [DEBOUNCE_SAMPLES-1:0] hist;
        t_lamp  lamp_expected[$];
        int unsigned ticks_noted;
        int unsigned mismatches;

        function new();
            cfg.long_press   = RST_LONG_PRESS;
            cfg.xlong_press  = RST_XLONG_PRESS;
            cfg.idle_timeout = RST_IDLE_TIMEOUT;
            cfg.batt_low     = RST_BATT_LOW;
            cfg.batt_crit    = RST_BATT_CRIT;
            cfg.batt_delay   = RST_BATT_DELAY;
            cfg.mode_count   = RST_MODE_COUNT;
            cfg.mode_levels  = RST_MODE_LEVELS;
            st       = '0;
            st.bwait = RST_BATT_DELAY;
            st.phase = PH_DRAIN;
            hist     = '0;
            ticks_noted = 0;
            mismatches  = 0;
        endfunction

        function int pending();
            return lamp_expected.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_LONG_PRESS:   cfg.long_press   = data[7:0];
                REG_XLONG_PRESS:  cfg.xlong_press  = data[7:0];
                REG_IDLE_TIMEOUT: cfg.idle_timeout = data[7:0];
                REG_BATT_LOW:     cfg.batt_low     = data[7:0];
                REG_BATT_CRIT:    cfg.batt_crit    = data[7:0];
                REG_BATT_DELAY:   cfg.batt_delay   = data[7:0];
                REG_MODE_COUNT:   cfg.mode_count   = data[3:0];
                REG_MODE_LEVELS:  cfg.mode_levels  = data;
            endcase
        endfunction

        function int modes_in_use();
            int n;
            n = cfg.mode_count;
            if (n < 2) n = 2;
            if (n > MAX_MODES) n = MAX_MODES;
            return n;
        endfunction

        function logic [7:0] level_at(logic [2:0] m);
            return cfg.mode_levels[8*m +: 8];
        endfunction

        // release is debounced: held while any recent sample was low
        function bit shift_held(logic sw);
            hist = {hist[DEBOUNCE_SAMPLES-2:0], sw};
            return hist != '0;
        endfunction

        function void go_previous();
            int n;
            n = modes_in_use();
            st.saved = {st.strobe, st.mode};
            if (st.strobe || st.mode == 3'd0 || int'(st.mode) >= n) st.mode = 3'(n - 1);
            else st.mode = st.mode - 3'd1;
            st.strobe = 1'b0;
        endfunction

        function void awake_update(logic sw, logic rdy, logic [7:0] val);
            int n;
            logic [7:0] limit;
            if (shift_held(sw)) begin
                if (st.press != COUNT_MAX) st.press = st.press + 8'd1;
                if (st.press == cfg.long_press) begin
                    go_previous();
                    st.idle = 8'd0;
                end
                if (st.press == cfg.xlong_press) st.strobe = 1'b1;
                st.bwait = cfg.batt_delay;
                return;
            end
            if (st.press > 8'd0 && st.press < cfg.long_press) begin
                if (st.strobe) begin
                    st.mode   = st.saved[2:0];
                    st.strobe = st.saved[3];
                end else begin
                    n = modes_in_use();
                    st.saved = {1'b0, st.mode};
                    st.mode = (int'(st.mode) + 1 >= n) ? 3'd0 : st.mode + 3'd1;
                    if (st.idle >= cfg.idle_timeout) st.mode = 3'd0;
                    st.idle = 8'd0;
                end
            end else begin
                if (st.idle != COUNT_MAX) st.idle = st.idle + 8'd1;
                if (st.bwait > 8'd0) st.bwait = st.bwait - 8'd1;
                if (st.bwait == 8'd0) begin
                    if (rdy) begin
                        limit = (!st.strobe && st.mode == 3'd1) ? cfg.batt_crit : cfg.batt_low;
                        if (val < limit) begin
                            if (st.lowcnt != LOWCNT_MAX) st.lowcnt = st.lowcnt + 3'd1;
                        end else begin
                            st.lowcnt = 3'd0;
                        end
                    end
                    if (st.lowcnt >= STEPDOWN_READINGS) begin
                        go_previous();
                        st.lowcnt = 3'd0;
                        st.bwait  = cfg.batt_delay;
                    end
                end
            end
            st.press = 8'd0;
        endfunction

        function void note_tick(logic sw, logic rdy, logic [7:0] val);
            logic [3:0] shown;
            t_lamp want;
            if (st.phase == PH_ASLEEP && sw) st.phase = PH_AWAKE;
            if (st.phase == PH_DRAIN) begin
                if (shift_held(sw)) begin
                    if (st.press != COUNT_MAX) begin
                        st.press = st.press + 8'd1;
                        if (st.press == cfg.xlong_press) begin
                            st.strobe = 1'b1;
                            st.phase  = PH_AWAKE;
                        end
                    end
                end else begin
                    st.press = 8'd0;
                    st.phase = PH_ASLEEP;
                end
            end else if (st.phase == PH_AWAKE) begin
                shown = {st.strobe, st.mode};
                awake_update(sw, rdy, val);
                if ({st.strobe, st.mode} != shown && !st.strobe && level_at(st.mode) == 8'd0)
                    st.phase = PH_DRAIN;
            end
            want.mode   = st.mode;
            want.strobe = st.strobe;
            want.pwm    = st.strobe ? STROBE_LEVEL : level_at(st.mode);
            want.tick   = ticks_noted;
            ticks_noted++;
            lamp_expected.push_back(want);
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= 60) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_lamp(input logic [2:0] m, input logic s, input logic [7:0] p);
            t_lamp want;
            if (lamp_expected.size() == 0) begin
                report_mismatch($sformatf("result with no tick pending: mode %0d strobe %0b pwm %0d",
                                          m, s, p));
                return;
            end
            want = lamp_expected.pop_front();
            if (m !== want.mode)
                report_mismatch($sformatf("tick %0d mode_index %0d, expected %0d",
                                          want.tick, m, want.mode));
            if (s !== want.strobe)
                report_mismatch($sformatf("tick %0d strobe_on %0b, expected %0b",
                                          want.tick, s, want.strobe));
            if (p !== want.pwm)
                report_mismatch($sformatf("tick %0d pwm_level %0d, expected %0d",
                                          want.tick, p, want.pwm));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_switch_low;
    logic        i_adc_ready;
    logic [7:0]  i_adc_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_mode_index;
    logic        o_strobe_on;
    logic [7:0]  o_pwm_level;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    mode_tracker sb;
    bit          calm = 1'b0;
    bit          want_holdoff = 1'b0;
    int unsigned ticks_sent = 0;

    eswitch_light_mode_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_switch_low (i_switch_low),
        .i_adc_ready  (i_adc_ready),
        .i_adc_value  (i_adc_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mode_index (o_mode_index),
        .o_strobe_on  (o_strobe_on),
        .o_pwm_level  (o_pwm_level),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_tick(i_switch_low, i_adc_ready, i_adc_value);
            if (o_out_valid && i_out_ready) sb.check_lamp(o_mode_index, o_strobe_on, o_pwm_level);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (want_holdoff) begin
                i_out_ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                want_holdoff = 1'b0;
            end
            i_out_ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    initial begin
        #1_000_000;
        $display("** eswitch_light_mode_controller: FAILED **");
        $finish;
    end

    task automatic send_tick(input logic sw, input logic rdy, input logic [7:0] val);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_switch_low <= sw;
        i_adc_ready  <= rdy;
        i_adc_value  <= val;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    task automatic flush_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // unused upper data bits carry noise
    task automatic set_config(input t_cfg c);
        flush_results();
        cfg_write(REG_LONG_PRESS,   64'({$urandom, c.long_press}));
        cfg_write(REG_XLONG_PRESS,  64'({$urandom, c.xlong_press}));
        cfg_write(REG_IDLE_TIMEOUT, 64'({$urandom, c.idle_timeout}));
        cfg_write(REG_BATT_LOW,     64'({$urandom, c.batt_low}));
        cfg_write(REG_BATT_CRIT,    64'({$urandom, c.batt_crit}));
        cfg_write(REG_BATT_DELAY,   64'({$urandom, c.batt_delay}));
        cfg_write(REG_MODE_COUNT,   64'({$urandom, c.mode_count}));
        cfg_write(REG_MODE_LEVELS,  c.mode_levels);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.long_press   = 8'($urandom_range(15, 1));
        c.xlong_press  = 8'($urandom_range(30, 1));
        c.idle_timeout = 8'($urandom_range(40));
        c.batt_low     = 8'($urandom);
        c.batt_crit    = 8'($urandom);
        c.batt_delay   = 8'($urandom_range(20));
        c.mode_count   = 4'($urandom);
        for (int b = 0; b < 8; b++)
            c.mode_levels[8*b +: 8] = ($urandom_range(99) < 30) ? 8'h00 : 8'($urandom);
        return c;
    endfunction

    // held press with the odd bounce inside
    task automatic hold_run(input int unsigned n);
        for (int i = 0; i < n; i++)
            send_tick(!(i > 0 && i + 1 < n && $urandom_range(99) < 8),
                      1'($urandom), 8'($urandom));
    endtask

    task automatic release_run(input int unsigned n, input bit low);
        logic [7:0] v;
        repeat (n) begin
            v = (low && $urandom_range(99) < 80) ? 8'($urandom_range(sb.cfg.batt_low))
                                                 : 8'($urandom);
            send_tick(1'b0, $urandom_range(99) < 60, v);
        end
    endtask

    task automatic random_phase(input int unsigned quota, input bit holdoff, input bit pause);
        int unsigned first, kind, hold, lp, xp;
        bit held_off, paused;
        first    = ticks_sent;
        held_off = !holdoff;
        paused   = !pause;
        while (ticks_sent - first < quota) begin
            lp = sb.cfg.long_press;
            xp = sb.cfg.xlong_press;
            if (!held_off && ticks_sent - first > quota / 3) begin
                want_holdoff = 1'b1;
                held_off = 1'b1;
            end
            if (!paused && ticks_sent - first > quota / 2) begin
                flush_results();
                paused = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 60) begin
                if (kind < 32) hold = 1 + $urandom_range(lp > 1 ? ((lp > 13) ? 11 : lp - 2) : 0);
                else if (kind < 47) hold = lp + $urandom_range(3);
                else if (kind < 59) hold = xp + $urandom_range(4);
                else hold = 256 + $urandom_range(4);  // press counter saturates
                hold_run(hold);
                // short releases keep the debounced press alive
                release_run($urandom_range(99) < 15 ? $urandom_range(3, 1)
                                                    : $urandom_range(7, 4), 1'b0);
            end else if (kind < 72) begin
                release_run(sb.cfg.batt_delay + $urandom_range(12, 4), 1'b1);
            end else if (kind < 90) begin
                release_run($urandom_range(30, 1), 1'b0);
            end else begin
                repeat ($urandom_range(10, 1))
                    send_tick(1'($urandom), 1'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        t_cfg c;
        sb = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_switch_low = 1'b0;
        i_adc_ready  = 1'b0;
        i_adc_value  = 8'd0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_LONG_PRESS;
        i_cfg_data   = 64'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sleep after reset, short/long/extra-long press, strobe exit, stepdown
        c.long_press   = 8'd2;
        c.xlong_press  = 8'd4;
        c.idle_timeout = 8'd3;
        c.batt_low     = 8'd130;
        c.batt_crit    = 8'd115;
        c.batt_delay   = 8'd1;
        c.mode_count   = 4'd3;
        c.mode_levels  = 64'h0000_0000_00FF_8000;
        set_config(c);
        send_tick(1'b0, 1'b0, 8'd0);
        send_tick(1'b0, 1'b1, 8'd255);
        send_tick(1'b0, 1'b1, 8'd0);
        send_tick(1'b1, 1'b0, 8'd0);
        repeat (4) send_tick(1'b0, 1'b0, 8'd0);
        repeat (4) send_tick(1'b1, 1'b0, 8'd0);
        repeat (4) send_tick(1'b0, 1'b0, 8'd0);
        send_tick(1'b1, 1'b0, 8'd0);
        repeat (4) send_tick(1'b0, 1'b0, 8'd0);
        send_tick(1'b0, 1'b1, 8'd255);
        repeat (4) send_tick(1'b0, 1'b1, 8'd0);

        c.long_press   = RST_LONG_PRESS;
        c.xlong_press  = RST_XLONG_PRESS;
        c.idle_timeout = RST_IDLE_TIMEOUT;
        c.batt_low     = RST_BATT_LOW;
        c.batt_crit    = RST_BATT_CRIT;
        c.batt_delay   = RST_BATT_DELAY;
        c.mode_count   = RST_MODE_COUNT;
        c.mode_levels  = RST_MODE_LEVELS;
        set_config(c);
        random_phase(230, 1'b0, 1'b0);

        c.long_press   = 8'd1;
        c.xlong_press  = 8'd1;
        c.idle_timeout = 8'd0;
        c.batt_low     = 8'd0;
        c.batt_crit    = 8'd0;
        c.batt_delay   = 8'd0;
        c.mode_count   = 4'd0;
        c.mode_levels  = 64'd0;
        set_config(c);
        random_phase(230, 1'b0, 1'b0);

        c.long_press   = 8'd255;
        c.xlong_press  = 8'd255;
        c.idle_timeout = 8'd255;
        c.batt_low     = 8'd255;
        c.batt_crit    = 8'd255;
        c.batt_delay   = 8'd255;
        c.mode_count   = 4'd15;
        c.mode_levels  = '1;
        set_config(c);
        random_phase(230, 1'b0, 1'b0);

        for (int k = 0; k < 4; k++) begin
            set_config(random_config());
            calm = (k == 2);
            random_phase(230, k == 0, k == 1);
        end
        calm = 1'b0;

        flush_results();
        repeat (10) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** eswitch_light_mode_controller: PASSED **");
        end else begin
            $display("** eswitch_light_mode_controller: FAILED **");
        end
        $finish;
    end
endmodule
